// ===== design/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types and constants for the single-plane polygon clipper.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int MAX_VERTS_DEF = 16;
  localparam int OUT_LIMIT     = 32;
  localparam int NW            = $clog2(OUT_LIMIT + 1);
  localparam int CRD_W         = 32;
  localparam int REG_IDX_W     = 3;

  typedef enum logic [1:0] {
    CLS_ON    = 2'd0,
    CLS_FRONT = 2'd1,
    CLS_BACK  = 2'd2,
    CLS_SPAN  = 2'd3
  } cls_t;

  localparam logic [REG_IDX_W-1:0] REG_NX     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NY     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NZ     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN = 3'd4;

  // one stored vertex
  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] z;
    logic [CRD_W-1:0] sdist;
    cls_t             cls;
  } vert_t;

  // one result, less the per-polygon overflow flag and the last mark
  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] z;
    cls_t             cls;
    logic             has_vertex;
  } res_t;

endpackage

// ===== design/polygon_plane_clipper.sv =====
// ----------------------------------------------------------------------------
// polygon_plane_clipper
// Clips a polygon against one configured plane (Sutherland-Hodgman, one plane).
// Vertex intake: one shared 34x34 multiplier forms 3 products per vertex;
// a vertex dropped on overflow skips the multiplier.
// Emit pass: each crossing point is found per axis by a restoring divider,
// one quotient bit per cycle.
// A class-only result follows the classification of the closing vertex; a
// clipped polygon holds its first result until the second is formed.
// Synchronous reset clears control state; the vertex RAM needs no clearing.
// ----------------------------------------------------------------------------
module polygon_plane_clipper
  import pcl_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,  // out_x, out_y, out_z
  output logic [3:0]           m_axis_tuser,  // side_class[1:0], has_vertex, overflow
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam logic signed [51:0] SAT_HI = 52'sh7FFFFFFF;
  localparam logic signed [51:0] SAT_LO = ~SAT_HI;
  localparam logic [5:0] Q_BITS = 6'd34;

  typedef enum logic [4:0] {
    S_IDLE, S_MX, S_MY, S_MZ, S_SUM, S_WR, S_CHK, S_SINGLE,
    S_RD0, S_RD0W, S_RDN, S_NXT, S_EMV, S_CM, S_CA, S_CD, S_DIV,
    S_CR, S_CPUSH, S_ADV, S_FIN
  } state_t;

  // configuration
  logic signed [31:0] nx, ny, nz, offset;
  logic [30:0]        margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      nx     <= '0;
      ny     <= '0;
      nz     <= 32'sd65536;
      offset <= '0;
      margin <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NX:     nx     <= cfg_data;
        REG_NY:     ny     <= cfg_data;
        REG_NZ:     nz     <= cfg_data;
        REG_OFFSET: offset <= cfg_data;
        REG_MARGIN: margin <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  state_t             state;
  logic signed [31:0] vx, vy, vz;
  logic               vlast;
  logic signed [67:0] prod;
  logic signed [51:0] acc;
  logic [CW-1:0]      count;
  cls_t               comb;
  logic               ovf;
  logic [IW-1:0]      idx;
  logic [NW-1:0]      n;
  vert_t              cur, nxt, first;
  logic [1:0]         axis;
  logic [32:0]        den_abs;
  logic               neg;
  logic [65:0]        dvd;
  logic [33:0]        dsh;
  logic [32:0]        rem;
  logic [33:0]        q;
  logic [5:0]         bitcnt;
  logic [2:0][31:0]   xing;
  res_t               pend;
  logic               pend_valid;
  logic               m_valid;
  res_t               out_res;
  logic               out_last;
  logic               out_ovf;

  // shared multiplier operands
  logic signed [33:0] ma, mb;
  logic [31:0]        ax_a, ax_b;

  always_comb begin
    case (axis)
      2'd0:    begin ax_a = cur.x; ax_b = nxt.x; end
      2'd1:    begin ax_a = cur.y; ax_b = nxt.y; end
      default: begin ax_a = cur.z; ax_b = nxt.z; end
    endcase
  end

  always_comb begin
    case (state)
      S_MX: begin ma = 34'(nx); mb = 34'(vx); end
      S_MY: begin ma = 34'(ny); mb = 34'(vy); end
      S_MZ: begin ma = 34'(nz); mb = 34'(vz); end
      S_CM: begin
        ma = $signed({{2{ax_b[31]}}, ax_b}) - $signed({{2{ax_a[31]}}, ax_a});
        mb = 34'($signed(cur.sdist));
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // distance, saturation and class of the incoming vertex
  logic signed [31:0] dist_w;
  logic signed [32:0] dist_e, marg_e;
  cls_t               cls_w;

  always_comb begin
    if (acc > SAT_HI)      dist_w = 32'sh7FFFFFFF;
    else if (acc < SAT_LO) dist_w = 32'sh80000000;
    else                   dist_w = acc[31:0];
    dist_e = {dist_w[31], dist_w};
    marg_e = $signed({2'b00, margin});
    if (dist_e > marg_e)       cls_w = CLS_FRONT;
    else if (dist_e < -marg_e) cls_w = CLS_BACK;
    else                       cls_w = CLS_ON;
  end

  // vertex RAM
  logic          wr_en;
  logic [IW-1:0] rd_addr;
  vert_t         wr_vert, rd_vert;
  logic [129:0]  rd_raw;

  assign wr_en   = (state == S_WR);
  assign wr_vert = '{x: vx, y: vy, z: vz, sdist: dist_w, cls: cls_w};
  assign rd_addr = (state == S_RDN) ? IW'(idx + 1'b1) : '0;
  assign rd_vert = vert_t'(rd_raw);

  pcl_ram #(
    .WIDTH($bits(vert_t)),
    .DEPTH(MAX_VERTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IW-1:0]),
    .wr_data(wr_vert),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  // emit helpers
  logic [CW-1:0]      idx_nx;
  logic               has_next;
  logic               can_push, out_free;
  logic               keep;
  logic [NW-1:0]      n_after;
  logic signed [65:0] num;
  logic [65:0]        mag;
  logic signed [32:0] den_s;
  logic [65:0]        dsum;
  logic [33:0]        trial;
  logic [31:0]        crs;

  assign idx_nx   = CW'(idx) + 1'b1;
  assign has_next = idx_nx < count;
  assign out_free = !m_valid || m_axis_tready;
  assign can_push = !pend_valid || out_free;
  assign keep     = (cur.cls == CLS_FRONT) || (cur.cls == CLS_ON);
  assign n_after  = keep ? n + 1'b1 : n;
  assign num      = prod[65:0];
  assign mag      = num[65] ? 66'(-num) : 66'(num);
  assign den_s    = $signed({cur.sdist[31], cur.sdist}) - $signed({nxt.sdist[31], nxt.sdist});
  assign dsum     = dvd + {33'd0, den_abs[32:1]};
  assign trial    = {rem, dsh[33]};
  assign crs      = neg ? ax_a - q[31:0] : ax_a + q[31:0];

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      comb       <= CLS_ON;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            vx    <= s_axis_tdata[31:0];
            vy    <= s_axis_tdata[63:32];
            vz    <= s_axis_tdata[95:64];
            vlast <= s_axis_tlast;
            if (count < CW'(MAX_VERTS)) begin
              state <= S_MX;
            end else begin
              ovf   <= 1'b1;
              state <= S_CHK;
            end
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          acc   <= 52'($signed(prod[63:16]));
          state <= S_MZ;
        end
        S_MZ: begin
          acc   <= acc + 52'($signed(prod[63:16]));
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + 52'($signed(prod[63:16])) - 52'(offset);
          state <= S_WR;
        end
        S_WR: begin
          comb  <= cls_t'(comb | cls_w);
          count <= count + 1'b1;
          state <= S_CHK;
        end
        S_CHK: begin
          n <= '0;
          if (!vlast)                 state <= S_IDLE;
          else if (comb != CLS_SPAN)  state <= S_SINGLE;
          else                        state <= S_RD0;
        end
        S_SINGLE: begin
          if (out_free) begin
            out_res  <= '{x: '0, y: '0, z: '0, cls: comb, has_vertex: 1'b0};
            out_last <= 1'b1;
            out_ovf  <= ovf;
            m_valid  <= 1'b1;
            count    <= '0;
            comb     <= CLS_ON;
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_RD0:  state <= S_RD0W;
        S_RD0W: begin
          first <= rd_vert;
          cur   <= rd_vert;
          idx   <= '0;
          state <= S_RDN;
        end
        S_RDN: state <= S_NXT;
        S_NXT: begin
          nxt   <= has_next ? rd_vert : first;
          state <= S_EMV;
        end
        S_EMV: begin
          if (!keep || can_push) begin
            if (keep) begin
              if (pend_valid) begin
                out_res  <= pend;
                out_last <= 1'b0;
                out_ovf  <= ovf;
                m_valid  <= 1'b1;
              end
              pend       <= '{x: cur.x, y: cur.y, z: cur.z, cls: CLS_SPAN, has_vertex: 1'b1};
              pend_valid <= 1'b1;
            end
            n    <= n_after;
            axis <= 2'd0;
            if (cur.cls != CLS_ON && (cur.cls | nxt.cls) == CLS_SPAN
                && n_after < NW'(OUT_LIMIT)) begin
              state <= S_CM;
            end else begin
              state <= S_ADV;
            end
          end
        end
        S_CM: state <= S_CA;
        S_CA: begin
          dvd     <= mag;
          neg     <= num[65] ^ den_s[32];
          den_abs <= den_s[32] ? 33'(-den_s) : 33'(den_s);
          state   <= S_CD;
        end
        S_CD: begin
          // round to nearest: add half the divisor, then divide
          rem    <= {1'b0, dsum[65:34]};
          dsh    <= dsum[33:0];
          bitcnt <= Q_BITS;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, den_abs}) begin
            rem <= 33'(trial - {1'b0, den_abs});
            q   <= {q[32:0], 1'b1};
          end else begin
            rem <= trial[32:0];
            q   <= {q[32:0], 1'b0};
          end
          dsh    <= {dsh[32:0], 1'b0};
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == 6'd1) state <= S_CR;
        end
        S_CR: begin
          xing[axis] <= crs;
          if (axis == 2'd2) begin
            state <= S_CPUSH;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_CM;
          end
        end
        S_CPUSH: begin
          if (can_push) begin
            if (pend_valid) begin
              out_res  <= pend;
              out_last <= 1'b0;
              out_ovf  <= ovf;
              m_valid  <= 1'b1;
            end
            pend       <= '{x: xing[0], y: xing[1], z: xing[2], cls: CLS_SPAN,
                            has_vertex: 1'b1};
            pend_valid <= 1'b1;
            n          <= n + 1'b1;
            state      <= S_ADV;
          end
        end
        S_ADV: begin
          if (!has_next || n >= NW'(OUT_LIMIT)) begin
            state <= S_FIN;
          end else begin
            cur   <= nxt;
            idx   <= idx + 1'b1;
            state <= S_RDN;
          end
        end
        S_FIN: begin
          // flush the held result as the final one
          if (out_free) begin
            out_res    <= pend;
            out_last   <= 1'b1;
            out_ovf    <= ovf;
            m_valid    <= 1'b1;
            pend_valid <= 1'b0;
            count      <= '0;
            comb       <= CLS_ON;
            ovf        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {out_res.z, out_res.y, out_res.x};
  assign m_axis_tuser  = {out_ovf, out_res.has_vertex, out_res.cls};
  assign m_axis_tlast  = out_last;

endmodule

// ===== design/pcl_ram.sv =====
// ----------------------------------------------------------------------------
// pcl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/pcl_checker.sv =====
// ----------------------------------------------------------------------------
// pcl_checker
// Port-level checks for the polygon clipper, bound to the top level.
// ----------------------------------------------------------------------------
module pcl_checker
  import pcl_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [95:0]          s_axis_tdata,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [95:0]          m_axis_tdata,
  input logic [3:0]           m_axis_tuser,
  input logic                 m_axis_tlast,
  input logic                 cfg_we,
  input logic [REG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_novert_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast && m_axis_tdata == 96'd0)
    else $error("class-only result must be final and carry zero coordinates");

  a_vert_span: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == CLS_SPAN)
    else $error("vertex result without spanning class");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind polygon_plane_clipper pcl_checker u_pcl_checker (.*);

// ===== dv/polygon_plane_clipper_test.sv =====
// ----------------------------------------------------------------------------
// polygon_plane_clipper_test
// Streams polygons into the single-plane clipper under several plane settings
// and checks every clipped vertex, class and flag against an in-bench model.
// ----------------------------------------------------------------------------
module polygon_plane_clipper_test;
  import pcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        lst;
  } vtx_req_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    cls_t        cls;
    logic        hv;
    logic        ovf;
    logic        lst;
  } clip_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  polygon_plane_clipper i_dut (.*);

  initial forever #5 clk = ~clk;

  // plane settings and per-polygon state of the predictor
  longint nrm_x, nrm_y, nrm_z, pl_off, margin;
  longint px[$], py[$], pz[$], pd[$];
  cls_t   pc[$];
  logic [1:0] cls_or;
  bit     ovf_seen;

  vtx_req_t  vtx_q[$];
  clip_res_t clip_q[$];
  int  errors = 0;
  int  n_res = 0;
  int  n_span = 0;
  int  n_vtx = 0;
  bit  hold_rx = 1'b0;
  int  idle_cnt = 0;

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint cross_pt(longint a, longint b, longint da, longint db);
    longint num, den, mag, q;
    num = (b - a) * da;
    den = da - db;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (den == 0) return a;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? a - q : a + q;
  endfunction

  function automatic void push_res(longint x, longint y, longint z, cls_t c, logic hv);
    clip_res_t r;
    r.x = x[31:0];
    r.y = y[31:0];
    r.z = z[31:0];
    r.cls = c;
    r.hv = hv;
    r.ovf = ovf_seen;
    r.lst = 1'b0;
    clip_q = {clip_q, r};
  endfunction

  function automatic void clip_vertex(vtx_req_t v);
    longint d, x, y, z;
    cls_t c;
    int cnt, nout, j;
    x = longint'(signed'(v.x));
    y = longint'(signed'(v.y));
    z = longint'(signed'(v.z));
    if (px.size() < MAX_VERTS_DEF) begin
      d = floor16(nrm_x * x) + floor16(nrm_y * y) + floor16(nrm_z * z) - pl_off;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      if (d > margin) c = CLS_FRONT;
      else if (d < -margin) c = CLS_BACK;
      else c = CLS_ON;
      px = {px, x};
      py = {py, y};
      pz = {pz, z};
      pd = {pd, d};
      pc = {pc, c};
      cls_or |= c;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!v.lst) return;
    cnt = px.size();
    nout = 0;
    if (cls_or != CLS_SPAN) begin
      push_res(0, 0, 0, cls_t'(cls_or), 1'b0);
      nout = 1;
    end else begin
      n_span++;
      for (int i = 0; i < cnt && nout < OUT_LIMIT; i++) begin
        j = (i + 1 < cnt) ? i + 1 : 0;
        if (pc[i] != CLS_BACK) begin
          push_res(px[i], py[i], pz[i], CLS_SPAN, 1'b1);
          nout++;
        end
        if (pc[i] == CLS_ON || (pc[i] | pc[j]) != CLS_SPAN || nout >= OUT_LIMIT)
          continue;
        push_res(cross_pt(px[i], px[j], pd[i], pd[j]), cross_pt(py[i], py[j], pd[i], pd[j]),
                 cross_pt(pz[i], pz[j], pd[i], pd[j]), CLS_SPAN, 1'b1);
        nout++;
      end
    end
    clip_q[$].lst = 1'b1;
    px.delete(); py.delete(); pz.delete(); pd.delete(); pc.delete();
    cls_or = 2'b00;
    ovf_seen = 1'b0;
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_vtx++;
        tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (vtx_q.size() > 0) begin
        vtx_req_t v;
        v = vtx_q.pop_front();
        clip_vertex(v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v.z, v.y, v.x};
        s_axis_tlast <= v.lst;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int rx_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        clip_res_t e;
        n_res++;
        if (clip_q.size() == 0) begin
          $display("%0t: result with nothing pending: got %h %b last %b", $realtime,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          e = clip_q.pop_front();
          if (m_axis_tdata !== {e.z, e.y, e.x} || m_axis_tuser !== {e.ovf, e.hv, e.cls} ||
              m_axis_tlast !== e.lst) begin
            $display("%0t: mismatch: expected %h %b last %b, got %h %b last %b", $realtime,
                     {e.z, e.y, e.x}, {e.ovf, e.hv, e.cls}, e.lst,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            errors++;
          end
        end
        rx_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_rx)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("polygon_plane_clipper regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NX: nrm_x = longint'(signed'(val));
      REG_NY: nrm_y = longint'(signed'(val));
      REG_NZ: nrm_z = longint'(signed'(val));
      REG_OFFSET: pl_off = longint'(signed'(val));
      REG_MARGIN: margin = longint'({1'b0, val[30:0]});
      default: ;
    endcase
  endtask

  task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] o, logic [31:0] m);
    cfg_write(REG_NX, a);
    cfg_write(REG_NY, b);
    cfg_write(REG_NZ, c);
    cfg_write(REG_OFFSET, o);
    cfg_write(REG_MARGIN, m);
  endtask

  task automatic drain();
    wait (vtx_q.size() == 0 && !s_axis_tvalid && clip_q.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  function automatic void add_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
    vtx_req_t v;
    v.x = x; v.y = y; v.z = z; v.lst = l;
    vtx_q = {vtx_q, v};
  endfunction

  // small coordinates keep most polygons spanning under a unit-ish plane
  function automatic logic [31:0] crd();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  // normal component within about one unit of zero
  function automatic logic [31:0] nrm_rand();
    return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
  endfunction

  function automatic void rand_poly();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      add_vtx(crd(), crd(), crd(), i == n - 1);
  endfunction

  initial begin
    nrm_x = 0; nrm_y = 0; nrm_z = 65536; pl_off = 0; margin = 66;
    cls_or = 2'b00;
    ovf_seen = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // reset plane z = 0: triangle crossing, all-front, all-back, on-plane
    add_vtx(0, 0, 32'h0001_0000, 0);
    add_vtx(32'h0001_0000, 0, 32'hffff_0000, 0);
    add_vtx(0, 32'h0001_0000, 32'h0002_0000, 1);
    add_vtx(0, 0, 32'h0005_0000, 0);
    add_vtx(1, 2, 32'h0006_0000, 1);
    add_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1);
    add_vtx(5, 5, 10, 0);
    add_vtx(32'hffff_ffff, 0, 32'hffff_ffc0, 1);
    // on-plane vertex between front and back, extreme coordinates
    add_vtx(0, 0, 32'h7fff_ffff, 0);
    add_vtx(32'hffff_ffff, 32'hffff_ffff, 0, 0);
    add_vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1);
    drain();
    // overflow: 18 alternating vertices
    for (int i = 0; i < 18; i++)
      add_vtx(i << 16, 0, (i % 2) ? 32'hfffe_0000 : 32'h0002_0000, i == 17);
    drain();
    set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    rand_poly(); rand_poly();
    drain();
    set_plane(32'h0001_0000, 32'h0001_0000, 0, 32'h0000_8000, 0);
    // long stall so the block backs up onto its input
    for (int i = 0; i < 6; i++) rand_poly();
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
    drain();
    for (int p = 0; p < 16; p++) begin
      if (p % 4 == 0) begin
        drain();
        set_plane($urandom_range(0, 3) == 0 ? $urandom() : nrm_rand(),
                  nrm_rand(), nrm_rand(),
                  32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)),
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 14));
      end
      rand_poly();
    end
    drain();
    cfg_write(REG_UNUSED, $urandom());
    $display("sent %0d vertices, checked %0d results, %0d spanning polygons",
             n_vtx, n_res, n_span);
    if (errors == 0)
      $display("polygon_plane_clipper regression: pass");
    else
      $display("polygon_plane_clipper regression: fail");
    $finish;
  end

endmodule
